@@ sv/odrc_pkg.sv @@
package odrc_pkg;

    // Minimum DCO frequency in MHz and the scaled constant the divider search starts from
    localparam int unsigned DCO_MIN_MHZ = 4850;
    localparam logic [15:0] N0_DCO = 16'((DCO_MIN_MHZ * 8) % 65536);

    // Bound on HS_DIV*N1 (11*128) that a candidate total must stay below, also the initial best total
    localparam logic [10:0] BEST_N_INIT = 11'(11 * 128);
    localparam logic [7:0]  N1_MAX      = 8'd128;

    // Shared divider geometry
    localparam int unsigned DVD_W  = 40;
    localparam int unsigned QUO_W  = 41;
    localparam int unsigned DSR_W  = 32;
    localparam int unsigned STEP_W = 7;

    localparam logic [STEP_W-1:0] STEPS_SMALL = 7'd16;
    localparam logic [STEP_W-1:0] STEPS_RFREQ = 7'(40 + 32);

    localparam logic [2:0] HS_LAST_IDX = 3'd5;

    // Register file
    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_CRYSTAL = 3'd0,
        REG_PPM     = 3'd1,
        REG_FILT_EN = 3'd2,
        REG_XLOW    = 3'd3,
        REG_XMID    = 3'd4,
        REG_XHIGH   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_FAIL   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_DIV0,
        S_HS_START,
        S_HS_WAIT,
        S_HS_EVAL,
        S_PICK_END,
        S_MUL,
        S_RDIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    // HS_DIV candidates in search order
    function automatic logic [3:0] hs_at(input logic [2:0] idx);
        logic [3:0] hs;
        unique case (idx)
            3'd0:    hs = 4'd11;
            3'd1:    hs = 4'd9;
            3'd2:    hs = 4'd7;
            3'd3:    hs = 4'd6;
            3'd4:    hs = 4'd5;
            3'd5:    hs = 4'd4;
            default: hs = 4'd0;
        endcase
        return hs;
    endfunction

endpackage

@@ sv/oscillator_divider_rfreq_calc.sv @@
// Oscillator divider and RFREQ calculator.
// Input channel (i_valid / o_stall): one beat carries a target frequency in MHz,
// 11.21 fixed point, and a flag that allows a small step without new dividers.
// Output channel (o_valid / i_stall): one beat per input beat with the six
// oscillator register bytes (registers 7..12), the update kind and the filter band.
// Configuration goes through the APB port: crystal frequency, ppm limit, filter
// enable and three crossover points at byte addresses 0,4,...,20; pready is tied high.
// All arithmetic runs through one shared radix-2 restoring divider, one quotient
// bit per cycle, under a small sequencer; the block takes one item at a time.
// On the small-step path the sequencer runs only the RFREQ divide (72 divider
// steps); a full load runs one 16-step divide for the DCO bound, six 16-step
// divides for the HS_DIV candidates, then the 72-step RFREQ divide. A frequency
// too low for a divisor ends the item before any divide, and a zero crystal fails
// it before the RFREQ divide. The next beat can be taken in the cycle after the
// result is registered. A finished result sits in the output register; when
// the receiver stalls, hold it there while the next beat may already be taken
// and worked on. A second finished result waits in the sequencer until the
// output register frees.
// Reset (synchronous, active low) loads the default configuration and clears the
// stored load frequency, dividers and band.
module oscillator_divider_rfreq_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [31:0]                 i_target_freq,
    input  logic                        i_allow_small_step,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_reg_hsdiv_n1,
    output logic [7:0]                  o_reg_n1_rfreq_top,
    output logic [7:0]                  o_reg_rfreq_b3,
    output logic [7:0]                  o_reg_rfreq_b2,
    output logic [7:0]                  o_reg_rfreq_b1,
    output logic [7:0]                  o_reg_rfreq_b0,
    output logic [1:0]                  o_update_kind,
    output logic [1:0]                  o_filter_band,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [odrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import odrc_pkg::*;

    // Configuration registers
    logic [31:0] r_crystal;
    logic [15:0] r_ppm;
    logic        r_filt_en;
    logic [15:0] r_xlow;
    logic [15:0] r_xmid;
    logic [15:0] r_xhigh;

    // State kept from item to item
    logic [31:0] r_last;
    logic [3:0]  r_hs;
    logic [7:0]  r_n1;
    logic [10:0] r_total;
    logic [1:0]  r_band;

    t_state      r_state;
    t_state      n_state;

    // Working registers of the current item
    logic [31:0] r_f;
    logic        r_small;
    logic        r_fail;
    t_kind       r_kind;
    logic [31:0] r_d15;
    logic [31:0] r_lim;
    logic [15:0] r_n0q;
    logic [2:0]  r_hs_idx;
    logic [10:0] r_best_n;
    logic [7:0]  r_best_n1;
    logic [3:0]  r_best_hs;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_b0;
    logic [7:0]  r_out_b1;
    logic [7:0]  r_out_b2;
    logic [7:0]  r_out_b3;
    logic [7:0]  r_out_b4;
    logic [7:0]  r_out_b5;
    t_kind       r_out_kind;
    logic [1:0]  r_out_band;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        in_acc;
    logic        out_free;
    logic        finish_go;

    logic [31:0] delta;
    logic [31:0] delta_abs;
    logic        take_small;
    logic [13:0] f_div;
    logic        div_zero;

    logic [3:0]  hs_cur;
    logic [15:0] eval_n1w;
    logic        eval_fits;
    logic [7:0]  eval_n1;
    logic [11:0] eval_n;
    logic        eval_better;

    logic [42:0] mul_full;
    logic [39:0] rfreq;
    logic [3:0]  hs_m4;
    logic [7:0]  n1_m1;
    logic [15:0] f_word;
    logic [1:0]  n_band;

    odrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_CRYSTAL: prdata = r_crystal;
            REG_PPM:     prdata = {16'b0, r_ppm};
            REG_FILT_EN: prdata = {31'b0, r_filt_en};
            REG_XLOW:    prdata = {16'b0, r_xlow};
            REG_XMID:    prdata = {16'b0, r_xmid};
            REG_XHIGH:   prdata = {16'b0, r_xhigh};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath pieces
    // ---------------------------------------------------------------------
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign finish_go = (r_state == S_FINISH) && out_free;

    // Small-change distance, 32-bit wrap; a difference with the top bit set is negated
    assign delta      = r_f - r_last;
    assign delta_abs  = delta[31] ? (32'd0 - delta) : delta;
    assign take_small = r_small && (r_d15 <= r_lim);

    assign f_div    = r_f[31:18];
    assign div_zero = (f_div == 14'd0);

    // Candidate N1 for the current HS_DIV: quotient + 1, rounded up to even unless 1
    assign hs_cur    = hs_at(r_hs_idx);
    assign eval_n1w  = div_rsp.quotient[15:0] + 16'd1;
    assign eval_fits = eval_n1w <= {8'b0, N1_MAX};
    assign eval_n1   = (eval_n1w[7:0] != 8'd1 && eval_n1w[0]) ? eval_n1w[7:0] + 8'd1
                                                              : eval_n1w[7:0];
    assign eval_n      = {8'b0, hs_cur} * {4'b0, eval_n1};
    assign eval_better = eval_fits && ({1'b0, r_best_n} > eval_n);

    // N*f truncated to 40 bits feeds the RFREQ divide
    assign mul_full = {32'b0, r_total} * {11'b0, r_f};

    // Round the 41-bit quotient by one bit, wrap to 40 bits
    assign rfreq = div_rsp.quotient[QUO_W-1:1] + {39'b0, div_rsp.quotient[0]};
    assign hs_m4 = r_hs - 4'd4;
    assign n1_m1 = r_n1 - 8'd1;

    // Band selection from the crossover points; keep the old band when disabled
    assign f_word = r_f[31:16];
    always_comb begin
        if (!r_filt_en) begin
            n_band = r_band;
        end else if (f_word < r_xlow) begin
            n_band = 2'd0;
        end else if (f_word < r_xmid) begin
            n_band = 2'd1;
        end else if (f_word < r_xhigh) begin
            n_band = 2'd2;
        end else begin
            n_band = 2'd3;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.steps    = STEPS_SMALL;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (take_small) begin
                    n_state = S_MUL;
                end else if (div_zero) begin
                    n_state = S_FINISH;
                end else begin
                    // DCO bound divided by the coarse frequency
                    div_req.start    = 1'b1;
                    div_req.steps    = STEPS_SMALL;
                    div_req.dividend = {N0_DCO, 24'b0};
                    div_req.divisor  = {18'b0, f_div};
                    n_state          = S_DIV0;
                end
            end
            S_DIV0: begin
                if (div_rsp.done) n_state = S_HS_START;
            end
            S_HS_START: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEPS_SMALL;
                div_req.dividend = {r_n0q, 24'b0};
                div_req.divisor  = {28'b0, hs_cur};
                n_state          = S_HS_WAIT;
            end
            S_HS_WAIT: begin
                if (div_rsp.done) n_state = S_HS_EVAL;
            end
            S_HS_EVAL: begin
                n_state = (r_hs_idx == HS_LAST_IDX) ? S_PICK_END : S_HS_START;
            end
            S_PICK_END: begin
                n_state = (r_best_hs == 4'd0) ? S_FINISH : S_MUL;
            end
            S_MUL: begin
                if (r_crystal == 32'd0) begin
                    n_state = S_FINISH;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.steps    = STEPS_RFREQ;
                    div_req.dividend = mul_full[DVD_W-1:0];
                    div_req.divisor  = r_crystal;
                    n_state          = S_RDIV;
                end
            end
            S_RDIV: begin
                if (div_rsp.done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_crystal   <= 32'd1917384130;
            r_ppm       <= 16'd3500;
            r_filt_en   <= 1'b0;
            r_xlow      <= '0;
            r_xmid      <= '0;
            r_xhigh     <= '0;
            r_last      <= '0;
            r_hs        <= '0;
            r_n1        <= '0;
            r_total     <= '0;
            r_band      <= '0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_CRYSTAL: r_crystal <= pwdata;
                    REG_PPM:     r_ppm     <= pwdata[15:0];
                    REG_FILT_EN: r_filt_en <= pwdata[0];
                    REG_XLOW:    r_xlow    <= pwdata[15:0];
                    REG_XMID:    r_xmid    <= pwdata[15:0];
                    REG_XHIGH:   r_xhigh   <= pwdata[15:0];
                    default:     ;
                endcase
            end

            // The load path records the frequency even if it later fails
            if (r_state == S_DECIDE && !take_small) r_last <= r_f;

            if (r_state == S_PICK_END && r_best_hs != 4'd0) begin
                r_hs    <= r_best_hs;
                r_n1    <= r_best_n1;
                r_total <= r_best_n;
            end

            if (finish_go) r_band <= n_band;

            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working registers and the output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_f     <= i_target_freq;
            r_small <= i_allow_small_step;
            r_fail  <= 1'b0;
        end
        unique case (r_state)
            S_CHECK: begin
                r_d15 <= (delta_abs << 4) - delta_abs;
                r_lim <= {16'b0, r_last[31:16]} * {16'b0, r_ppm};
            end
            S_DECIDE: begin
                r_kind <= take_small ? KIND_DIRECT : KIND_LOAD;
                if (!take_small && div_zero) r_fail <= 1'b1;
            end
            S_DIV0: begin
                if (div_rsp.done) begin
                    r_n0q     <= div_rsp.quotient[15:0];
                    r_hs_idx  <= '0;
                    r_best_n  <= BEST_N_INIT;
                    r_best_n1 <= '0;
                    r_best_hs <= '0;
                end
            end
            S_HS_EVAL: begin
                if (eval_better) begin
                    r_best_n  <= eval_n[10:0];
                    r_best_n1 <= eval_n1;
                    r_best_hs <= hs_cur;
                end
                r_hs_idx <= r_hs_idx + 3'd1;
            end
            S_PICK_END: begin
                if (r_best_hs == 4'd0) r_fail <= 1'b1;
            end
            S_MUL: begin
                if (r_crystal == 32'd0) r_fail <= 1'b1;
            end
            default: ;
        endcase

        if (finish_go) begin
            r_out_band <= n_band;
            if (r_fail) begin
                r_out_kind <= KIND_FAIL;
                r_out_b0   <= '0;
                r_out_b1   <= '0;
                r_out_b2   <= '0;
                r_out_b3   <= '0;
                r_out_b4   <= '0;
                r_out_b5   <= '0;
            end else begin
                r_out_kind <= r_kind;
                r_out_b0   <= {hs_m4[2:0], n1_m1[6:2]};
                r_out_b1   <= {n1_m1[1:0], 6'b0} | rfreq[39:32];
                r_out_b2   <= rfreq[31:24];
                r_out_b3   <= rfreq[23:16];
                r_out_b4   <= rfreq[15:8];
                r_out_b5   <= rfreq[7:0];
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_reg_hsdiv_n1     = r_out_b0;
    assign o_reg_n1_rfreq_top = r_out_b1;
    assign o_reg_rfreq_b3     = r_out_b2;
    assign o_reg_rfreq_b2     = r_out_b3;
    assign o_reg_rfreq_b1     = r_out_b4;
    assign o_reg_rfreq_b0     = r_out_b5;
    assign o_update_kind      = r_out_kind;
    assign o_filter_band      = r_out_band;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_div_busy_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_state == S_DIV0 || r_state == S_HS_WAIT || r_state == S_RDIV))
        else $error("divider running outside a wait state");

    a_fail_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_update_kind == KIND_FAIL) |->
            (o_reg_hsdiv_n1 == 8'd0 && o_reg_n1_rfreq_top == 8'd0 &&
             o_reg_rfreq_b3 == 8'd0 && o_reg_rfreq_b2 == 8'd0 &&
             o_reg_rfreq_b1 == 8'd0 && o_reg_rfreq_b0 == 8'd0))
        else $error("failure result carries register bytes");

    a_hs_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hs == 4'd0 || r_hs == 4'd4 || r_hs == 4'd5 || r_hs == 4'd6 ||
         r_hs == 4'd7 || r_hs == 4'd9 || r_hs == 4'd11))
        else $error("stored HS_DIV not a legal divider");

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_total} == {8'b0, r_hs} * {4'b0, r_n1}))
        else $error("stored total divider differs from HS_DIV*N1");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !(in_acc && $past(r_state) == S_FINISH && !$past(out_free)))
        else $error("item taken while a result was still waiting");

endmodule

@@ sv/odrc_div.sv @@
module odrc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  odrc_pkg::t_div_req  i_req,
    output odrc_pkg::t_div_rsp  o_rsp
);
    import odrc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [DVD_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;

    logic [DSR_W:0]    step_val;
    logic [DSR_W:0]    step_sub;
    logic              step_ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        step_val = {r_rem, r_dvd[DVD_W-1]};
        step_sub = step_val - {1'b0, r_dsr};
        step_ge  = step_val >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.steps;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            r_rem <= step_ge ? step_sub[DSR_W-1:0] : step_val[DSR_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], step_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ verif/oscillator_divider_rfreq_calc_tb.sv @@
module oscillator_divider_rfreq_calc_tb;

    import odrc_pkg::*;

    // Cycles without any accepted beat or register access before the run is abandoned.
    // The slowest item is a full load, plus a receiver stall.
    localparam int unsigned QUIET_LIMIT = 5000;
    // Settle time after the last result, longer than a full load.
    localparam int unsigned TAIL_CYCLES = 300;

    // One tuning request as it goes over the input channel
    typedef struct packed {
        logic [31:0] freq;
        logic        small_ok;
    } t_tune_req;

    // Register bytes 7..12, update kind and filter band of one result beat
    typedef struct packed {
        logic [7:0] hsdiv_n1;
        logic [7:0] n1_rfreq_top;
        logic [7:0] rfreq_b3;
        logic [7:0] rfreq_b2;
        logic [7:0] rfreq_b1;
        logic [7:0] rfreq_b0;
        t_kind      kind;
        logic [1:0] band;
    } t_osc_regs;

    logic                i_clk              = 1'b0;
    logic                i_rst_n            = 1'b0;
    logic                i_valid            = 1'b0;
    logic                o_stall;
    logic [31:0]         i_target_freq      = '0;
    logic                i_allow_small_step = 1'b0;
    logic                o_valid;
    logic                i_stall            = 1'b0;
    logic [7:0]          o_reg_hsdiv_n1;
    logic [7:0]          o_reg_n1_rfreq_top;
    logic [7:0]          o_reg_rfreq_b3;
    logic [7:0]          o_reg_rfreq_b2;
    logic [7:0]          o_reg_rfreq_b1;
    logic [7:0]          o_reg_rfreq_b0;
    logic [1:0]          o_update_kind;
    logic [1:0]          o_filter_band;
    logic                psel               = 1'b0;
    logic                penable            = 1'b0;
    logic                pwrite             = 1'b0;
    logic [ADDR_W-1:0]   paddr              = '0;
    logic [31:0]         pwdata             = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor copy of the configuration, starting at the reset defaults
    logic [31:0] xtal_q      = 32'd1917384130;
    logic [15:0] ppm_q       = 16'd3500;
    logic        filt_en_q   = 1'b0;
    logic [15:0] xover_lo_q  = '0;
    logic [15:0] xover_mid_q = '0;
    logic [15:0] xover_hi_q  = '0;

    // Predictor copy of the stored load frequency, dividers and band
    logic [31:0] last_load_q = '0;
    logic [3:0]  hs_div_q    = '0;
    logic [7:0]  n1_q        = '0;
    logic [10:0] total_div_q = '0;
    logic [1:0]  band_q      = '0;

    t_tune_req   freq_req_q[$];
    t_osc_regs   expected_regs_q[$];
    t_tune_req   cur_req;

    int unsigned send_gap       = 0;
    int unsigned hold_cycles    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned fail_count     = 0;
    bit          sender_idles   = 1'b0;
    bit          receiver_idles = 1'b0;

    always #5 i_clk = ~i_clk;

    oscillator_divider_rfreq_calc u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_target_freq      (i_target_freq),
        .i_allow_small_step (i_allow_small_step),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_reg_hsdiv_n1     (o_reg_hsdiv_n1),
        .o_reg_n1_rfreq_top (o_reg_n1_rfreq_top),
        .o_reg_rfreq_b3     (o_reg_rfreq_b3),
        .o_reg_rfreq_b2     (o_reg_rfreq_b2),
        .o_reg_rfreq_b1     (o_reg_rfreq_b1),
        .o_reg_rfreq_b0     (o_reg_rfreq_b0),
        .o_update_kind      (o_update_kind),
        .o_filter_band      (o_filter_band),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Small-change test: wrapped distance to the last load, times 15, against the
    // upper half of the last load scaled by the ppm limit. The distance times 15 wraps at 32 bits.
    function automatic logic within_ppm(logic [31:0] f);
        logic [31:0] gap;
        logic [31:0] bound;
        gap   = f - last_load_q;
        bound = {16'b0, last_load_q[31:16]} * {16'b0, ppm_q};
        if (gap[31]) begin
            gap = -gap;
        end
        gap = gap * 32'd15;
        return gap <= bound;
    endfunction

    // Lowest HS_DIV*N1 that keeps the DCO above its minimum; keep the old dividers
    // when the frequency is too low for a divisor or no candidate fits.
    function automatic logic search_dividers(logic [31:0] f);
        int unsigned span;
        int unsigned n0;
        int unsigned n1;
        int unsigned total;
        int unsigned best_total;
        int unsigned best_n1;
        int unsigned best_hs;
        span = f >> 18;
        if (span == 0) begin
            return 1'b0;
        end
        n0         = ((DCO_MIN_MHZ * 8) % 65536) / span;
        best_total = 11 * 128;
        best_n1    = 0;
        best_hs    = 0;
        for (int hs = 11; hs > 3; hs--) begin
            if (hs != 8 && hs != 10) begin
                n1 = n0 / hs + 1;
                if (n1 <= 128) begin
                    // N1 must be 1 or even
                    if (n1 != 1 && n1[0]) begin
                        n1++;
                    end
                    total = hs * n1;
                    if (best_total > total) begin
                        best_total = total;
                        best_n1    = n1;
                        best_hs    = hs;
                    end
                end
            end
        end
        if (best_hs == 0) begin
            return 1'b0;
        end
        hs_div_q    = 4'(best_hs);
        n1_q        = 8'(best_n1);
        total_div_q = 11'(best_total);
        return 1'b1;
    endfunction

    // Six register bytes from the stored dividers; RFREQ is the rounded
    // quotient of trunc40(N*f)*2^32 over the crystal, kept to 40 bits.
    function automatic logic [47:0] register_bytes(logic [31:0] f);
        logic [63:0] wide;
        logic [39:0] prod;
        logic [71:0] quo;
        logic [39:0] rf;
        logic [7:0]  n1m;
        logic [3:0]  hsm;
        wide = 64'(total_div_q) * 64'(f);
        prod = wide[39:0];
        quo  = {prod, 32'b0} / 72'(xtal_q);
        rf   = 40'((quo >> 1) + 72'(quo[0]));
        n1m  = n1_q - 8'd1;
        hsm  = hs_div_q - 4'd4;
        return {hsm[2:0], n1m[6:2],
                {n1m[1:0], 6'b0} | rf[39:32],
                rf[31:24], rf[23:16], rf[15:8], rf[7:0]};
    endfunction

    function automatic t_osc_regs predict_tuning(logic [31:0] f, logic small_ok);
        t_osc_regs r;
        logic      ok;
        r = '0;
        if (small_ok && within_ppm(f)) begin
            r.kind = KIND_DIRECT;
            ok     = xtal_q != 0;
        end else begin
            // The load frequency moves even if the divider search fails
            last_load_q = f;
            r.kind      = KIND_LOAD;
            ok          = search_dividers(f) && xtal_q != 0;
        end
        if (ok) begin
            {r.hsdiv_n1, r.n1_rfreq_top, r.rfreq_b3, r.rfreq_b2, r.rfreq_b1, r.rfreq_b0} =
                register_bytes(f);
        end else begin
            r.kind = KIND_FAIL;
        end
        // With the filter off the band holds whatever it was
        if (filt_en_q) begin
            if (f[31:16] < xover_lo_q) begin
                band_q = 2'd0;
            end else if (f[31:16] < xover_mid_q) begin
                band_q = 2'd1;
            end else if (f[31:16] < xover_hi_q) begin
                band_q = 2'd2;
            end else begin
                band_q = 2'd3;
            end
        end
        r.band = band_q;
        return r;
    endfunction

    function automatic int unsigned idle_draw(bit enabled);
        return enabled ? $urandom_range(0, 6) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued requests, predict each beat as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                expected_regs_q.push_back(predict_tuning(cur_req.freq, cur_req.small_ok));
                send_gap = idle_draw(sender_idles);
            end
            if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (freq_req_q.size() != 0) begin
                cur_req = freq_req_q.pop_front();
                i_valid            <= 1'b1;
                i_target_freq      <= cur_req.freq;
                i_allow_small_step <= cur_req.small_ok;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each taken beat against the oldest prediction,
    // then stall a random number of cycles while a result is on offer
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_regs_q.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end else begin
                    t_osc_regs want;
                    want = expected_regs_q.pop_front();
                    compare_field("reg_hsdiv_n1",     want.hsdiv_n1,     o_reg_hsdiv_n1);
                    compare_field("reg_n1_rfreq_top", want.n1_rfreq_top, o_reg_n1_rfreq_top);
                    compare_field("reg_rfreq_b3",     want.rfreq_b3,     o_reg_rfreq_b3);
                    compare_field("reg_rfreq_b2",     want.rfreq_b2,     o_reg_rfreq_b2);
                    compare_field("reg_rfreq_b1",     want.rfreq_b1,     o_reg_rfreq_b1);
                    compare_field("reg_rfreq_b0",     want.rfreq_b0,     o_reg_rfreq_b0);
                    compare_field("update_kind",      8'(want.kind),     8'(o_update_kind));
                    compare_field("filter_band",      8'(want.band),     8'(o_filter_band));
                end
                hold_cycles = idle_draw(receiver_idles);
            end else if (o_valid && hold_cycles != 0) begin
                hold_cycles--;
            end
            i_stall <= (hold_cycles != 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("oscillator_divider_rfreq_calc: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access cycle until pready; mirror it in the predictor
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CRYSTAL: xtal_q      = value;
            REG_PPM:     ppm_q       = value[15:0];
            REG_FILT_EN: filt_en_q   = value[0];
            REG_XLOW:    xover_lo_q  = value[15:0];
            REG_XMID:    xover_mid_q = value[15:0];
            REG_XHIGH:   xover_hi_q  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] xtal, logic [15:0] ppm, logic filt,
                             logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
        write_reg(REG_CRYSTAL, xtal);
        write_reg(REG_PPM,     32'(ppm));
        write_reg(REG_FILT_EN, 32'(filt));
        write_reg(REG_XLOW,    32'(lo));
        write_reg(REG_XMID,    32'(mid));
        write_reg(REG_XHIGH,   32'(hi));
        // leave the edge so queue pushes never share a step with the driver
        @(negedge i_clk);
    endtask

    task automatic push_req(logic [31:0] f, logic small_ok);
        t_tune_req req;
        req.freq     = f;
        req.small_ok = small_ok;
        freq_req_q.push_back(req);
    endtask

    // Hold until every queued request is taken and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (freq_req_q.size() != 0 || i_valid || expected_regs_q.size() != 0);
    endtask

    // Mostly a full load followed by a run of small steps around it, some right
    // at or just past the ppm edge; the rest is raw noise on both fields.
    task automatic queue_tuning_runs(int count);
        int          n;
        int unsigned roll;
        int unsigned steps;
        logic [31:0] anchor;
        logic [31:0] reach;
        logic [31:0] delta;
        n = 0;
        while (n < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                push_req($urandom, 1'($urandom_range(0, 1)));
                n++;
            end else begin
                // 1..200 MHz in 11.21 most of the time, anywhere otherwise
                anchor = (roll < 16) ? $urandom : $urandom_range(32'h0020_0000, 32'h1900_0000);
                push_req(anchor, roll < 20);
                n++;
                steps = $urandom_range(0, 5);
                reach = ({16'b0, anchor[31:16]} * {16'b0, ppm_q}) / 15;
                while (steps != 0 && n < count) begin
                    case ($urandom_range(0, 9))
                        0:       delta = reach + 1 + $urandom_range(0, 1000);
                        1:       delta = reach;
                        default: delta = $urandom_range(0, reach);
                    endcase
                    push_req($urandom_range(0, 1) ? anchor + delta : anchor - delta,
                             $urandom_range(0, 9) != 0);
                    n++;
                    steps--;
                end
            end
        end
    endtask

    task automatic setup_phase(int phase);
        logic [15:0] lo;
        logic [15:0] mid;
        lo  = 16'($urandom_range(0, 60 << 5));
        mid = lo + 16'($urandom_range(0, 60 << 5));
        case (phase)
            // defaults with sensible HF band edges at 4, 10 and 30 MHz
            0: write_all(32'd1917384130, 16'd3500, 1'b1, 16'd128, 16'd320, 16'd960);
            // largest crystal, zero tolerance, every crossover at its top
            1: write_all(32'hFFFF_FFFF, 16'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            // smallest nonzero crystal drives RFREQ into its 40-bit wrap; filter off
            2: write_all(32'd1, 16'hFFFF, 1'b0, 16'd200, 16'd100, 16'd50);
            3: write_all($urandom_range(32'h6C00_0000, 32'h7800_0000),
                         16'($urandom_range(1, 20000)), 1'b1,
                         lo, mid, mid + 16'($urandom_range(0, 80 << 5)));
            5: write_all(32'h7200_0000 + $urandom_range(0, 32'h00FF_FFFF), 16'd100, 1'b1,
                         lo, mid, mid + 16'($urandom_range(0, 80 << 5)));
            default: write_all($urandom, 16'($urandom), 1'($urandom_range(0, 1)),
                               16'($urandom), 16'($urandom), 16'($urandom));
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at the reset configuration, no idling
        push_req(32'h0000_0000, 1'b1);     // small step before any load: zero dividers
        push_req(32'h0000_0000, 1'b0);     // load at zero frequency: zero divisor
        push_req(32'h0003_FFFF, 1'b0);     // just too low for a divisor
        push_req(32'h0004_0000, 1'b0);     // lowest divisor, no divider fits
        push_req(32'd27 << 18, 1'b0);      // HS_DIV 11 needs an N1 above 128: no divider fits
        push_req(32'd28 << 18, 1'b0);      // first frequency where HS_DIV 11 fits
        push_req(32'd14 << 21, 1'b0);      // 14 MHz load
        push_req((32'd14 << 21) + 100, 1'b1);
        push_req((32'd14 << 21) - 100, 1'b1);   // distance wraps negative
        push_req((32'd14 << 21) + 32'h0010_0000, 1'b1);  // too far: falls back to a load
        push_req(32'd160 << 21, 1'b0);
        push_req(32'd1 << 21, 1'b0);       // 1 MHz: no divider reaches the DCO minimum
        push_req(32'hFFFF_FFFF, 1'b0);     // top of the range
        push_req(32'hFFFF_FFFF, 1'b1);     // zero distance
        push_req(32'h0000_0000, 1'b1);     // distance of one through the 32-bit wrap
        push_req(32'h2000_0000, 1'b0);
        push_req(32'h3111_1112, 1'b1);     // times 15 wraps to a tiny value: passes
        push_req(32'h8000_0000, 1'b0);
        push_req(32'h0000_0000, 1'b1);     // distance with bit 31 set stays huge
        wait_drained();

        // Zero crystal fails on both paths; crossovers at zero put everything in band 3
        write_all(32'd0, 16'hFFFF, 1'b1, 16'd0, 16'd0, 16'd0);
        push_req(32'd14 << 21, 1'b0);
        push_req((32'd14 << 21) + 50, 1'b1);
        push_req(32'd0, 1'b0);
        push_req(32'd7 << 21, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            setup_phase(phase);
            sender_idles   = (phase % 3) != 0;
            receiver_idles = (phase % 4) != 1;
            if (phase == 3) begin
                // stop feeding halfway and let the block run completely dry
                queue_tuning_runs(100);
                wait_drained();
                queue_tuning_runs(105);
            end else begin
                queue_tuning_runs(205);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("oscillator_divider_rfreq_calc: match");
        end else begin
            $display("oscillator_divider_rfreq_calc: mismatch");
        end
        $finish;
    end

endmodule
